// File: design/hsfd_pkg.sv
// ---------------------------------------------------------------------------
// hsfd_pkg: shared types and constants of the sensor frame decoder
// Holds the CRC-8 step, the frame positions, the status codes and the
// record that the byte front end hands to the conversion back end.
// ---------------------------------------------------------------------------
package hsfd_pkg;

  // CRC-8 settings used on each two-byte word.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte positions within the six-byte frame.
  localparam logic [2:0] POS_TEMP_HI = 3'd0;
  localparam logic [2:0] POS_TEMP_LO = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI = 3'd3;
  localparam logic [2:0] POS_HUM_LO = 3'd4;
  localparam logic [2:0] POS_HUM_CRC = 3'd5;

  // Status codes of a decoded frame.
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_TEMP_CRC = 2'd1;
  localparam logic [1:0] STATUS_HUM_CRC = 2'd2;

  // Conversion constants.
  localparam logic [14:0] TEMP_SPAN = 15'd17500;
  localparam logic [13:0] HUM_SPAN = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [16:0] FULL_SCALE = 17'd65535;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // One completed frame as seen by the back end.
  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_humidity;
    logic [1:0]  status;
  } frame_rec_t;

  // Bitwise CRC-8 update over one byte, MSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: design/hsfd_front.sv
// ---------------------------------------------------------------------------
// hsfd_front: byte front end
// Tracks the frame position, runs the CRC-8 over each word, collects the
// raw words and pushes one frame record after the last byte.
// ---------------------------------------------------------------------------
module hsfd_front
  import hsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  output logic       push,
  output frame_rec_t push_rec
);

  logic [2:0]  pos;
  logic [7:0]  crc;
  logic [15:0] temp_word;
  logic [15:0] humidity_word;
  logic        temp_good;

  logic [2:0] pos_eff;
  logic [7:0] crc_eff;
  logic [7:0] crc_step;
  logic [1:0] status_next;

  // A frame start or an out-of-range position restarts the frame.
  always_comb begin
    if (frame_start || (pos > POS_HUM_CRC)) begin
      pos_eff = POS_TEMP_HI;
      crc_eff = CRC_INIT;
    end else begin
      pos_eff = pos;
      crc_eff = crc;
    end
    crc_step = crc8_update(crc_eff, data_byte);
  end

  // Status of the frame that closes with this byte; the temperature check wins.
  always_comb begin
    if (!temp_good) begin
      status_next = STATUS_TEMP_CRC;
    end else if (crc_eff != data_byte) begin
      status_next = STATUS_HUM_CRC;
    end else begin
      status_next = STATUS_OK;
    end
  end

  assign push = byte_valid && (pos_eff == POS_HUM_CRC);
  assign push_rec = '{raw_temp: temp_word, raw_humidity: humidity_word, status: status_next};

  // Position and CRC tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_TEMP_HI;
      crc       <= CRC_INIT;
      temp_good <= 1'b0;
    end else if (byte_valid) begin
      case (pos_eff)
        POS_TEMP_HI, POS_TEMP_LO, POS_HUM_HI, POS_HUM_LO: begin
          crc <= crc_step;
          pos <= pos_eff + 3'd1;
        end
        POS_TEMP_CRC: begin
          temp_good <= (crc_eff == data_byte);
          crc       <= CRC_INIT;
          pos       <= pos_eff + 3'd1;
        end
        default: begin
          crc <= CRC_INIT;
          pos <= POS_TEMP_HI;
        end
      endcase
    end
  end

  // Word assembly, big-endian.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_word     <= '0;
      humidity_word <= '0;
    end else if (byte_valid) begin
      case (pos_eff)
        POS_TEMP_HI: temp_word <= {data_byte, 8'h00};
        POS_TEMP_LO: temp_word <= {temp_word[15:8], data_byte};
        POS_HUM_HI:  humidity_word <= {data_byte, 8'h00};
        POS_HUM_LO:  humidity_word <= {humidity_word[15:8], data_byte};
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/hsfd_queue.sv
// ---------------------------------------------------------------------------
// hsfd_queue: frame record queue
// A short first-in first-out queue of frame records that lets the byte
// front end and the conversion back end stall independently.
// ---------------------------------------------------------------------------
module hsfd_queue
  import hsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_rec_t push_rec,
  output logic       full,
  output logic       pop_valid,
  input  logic       pop,
  output frame_rec_t pop_rec
);

  frame_rec_t entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_rec   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

// File: design/hsfd_back.sv
// ---------------------------------------------------------------------------
// hsfd_back: conversion back end
// Scales the raw words in a multiply stage, divides by full scale with a
// shift and one correction step, and holds the result in the output register.
// ---------------------------------------------------------------------------
module hsfd_back
  import hsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rec_valid,
  output logic        rec_pop,
  input  frame_rec_t  rec,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] raw_temp,
  output logic [15:0] raw_humidity,
  output logic [14:0] temperature_centi,
  output logic [13:0] humidity_centi,
  output logic [1:0]  status
);

  logic        s1_valid;
  frame_rec_t  s1_rec;
  logic [30:0] s1_tprod;
  logic [29:0] s1_hprod;

  logic        out_load;
  logic        s1_ready;

  logic [14:0] t_est;
  logic [13:0] h_est;
  logic [16:0] t_rem;
  logic [16:0] h_rem;
  logic [14:0] t_quo;
  logic [13:0] h_quo;

  assign out_load = !out_valid || out_ready;
  assign s1_ready = !s1_valid || out_load;
  assign rec_pop  = rec_valid && s1_ready;

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      s1_rec   <= rec;
      s1_tprod <= 31'(rec.raw_temp) * 31'(TEMP_SPAN);
      s1_hprod <= 30'(rec.raw_humidity) * 30'(HUM_SPAN);
    end
  end

  // Division by 65535: the shift underestimates by at most one, and the
  // remainder stays below twice the divisor, so one compare fixes it.
  always_comb begin
    t_est = s1_tprod[30:16];
    h_est = s1_hprod[29:16];
    t_rem = {1'b0, s1_tprod[15:0]} + {2'b00, t_est};
    h_rem = {1'b0, s1_hprod[15:0]} + {3'b000, h_est};
    t_quo = (t_rem >= FULL_SCALE) ? t_est + 15'd1 : t_est;
    h_quo = (h_rem >= FULL_SCALE) ? h_est + 14'd1 : h_est;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      raw_temp          <= s1_rec.raw_temp;
      raw_humidity      <= s1_rec.raw_humidity;
      temperature_centi <= t_quo - TEMP_OFFSET;
      humidity_centi    <= h_quo;
      status            <= s1_rec.status;
    end
  end

endmodule

// File: design/humidity_sensor_frame_decoder_top.sv
// ---------------------------------------------------------------------------
// humidity_sensor_frame_decoder_top: sensor measurement frame decoder
// Decodes six-byte temperature/humidity frames and emits converted results.
// ---------------------------------------------------------------------------
// The block takes one frame byte per beat on the slave side, with s_tuser set
// on the first byte of a frame, and after the sixth byte emits one beat that
// carries the raw words, the temperature in hundredths of a degree Celsius,
// the humidity in hundredths of a percent and a CRC status code. A byte is
// taken every cycle while the four-entry record queue has room; the result of
// a frame passes through the queue, a multiply stage and the output register.
// A frame with a bad CRC is still reported with its words; only the status
// code marks the error.
// ---------------------------------------------------------------------------
module humidity_sensor_frame_decoder_top
  import hsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] raw_temp, [31:16] raw_humidity, [46:32] temperature_centi,
  // [60:47] humidity_centi, [62:61] status, [63] zero
  output logic [63:0] m_tdata
);

  logic       q_full;
  logic       push;
  frame_rec_t push_rec;
  logic       pop_valid;
  logic       pop;
  frame_rec_t pop_rec;

  logic [15:0] raw_temp;
  logic [15:0] raw_humidity;
  logic [14:0] temperature_centi;
  logic [13:0] humidity_centi;
  logic [1:0]  status;

  // A byte is taken only while a finished frame can be queued.
  assign s_tready = !q_full;

  hsfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (s_tvalid && s_tready),
    .data_byte   (s_tdata),
    .frame_start (s_tuser[0]),
    .push        (push),
    .push_rec    (push_rec)
  );

  hsfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_rec   (pop_rec)
  );

  hsfd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .rec_valid         (pop_valid),
    .rec_pop           (pop),
    .rec               (pop_rec),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .raw_temp          (raw_temp),
    .raw_humidity      (raw_humidity),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .status            (status)
  );

  // Pack the result beat, first field in the lowest bits.
  assign m_tdata = {1'b0, status, humidity_centi, temperature_centi, raw_humidity, raw_temp};

endmodule
